// ----- rtl/mp_pkg.sv -----
// ----------------------------------------------------------------------------
// mp_pkg
// Shared constants, types and the stride reciprocal table for the max pool core.
// ----------------------------------------------------------------------------
`default_nettype none

package mp_pkg;

  localparam int MAX_KERNEL = 8;
  localparam int MAX_WIDTH  = 256;

  localparam int SMP_W      = 16;
  localparam int KS_W       = 4;
  localparam int DIM_W      = 9;
  localparam int IDX_W      = 8;
  localparam int SLOT_W     = $clog2(MAX_KERNEL);
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ADDR_W     = SLOT_W + COL_W;
  localparam int RAM_DEPTH  = MAX_KERNEL * MAX_WIDTH;

  // x / s == (x * RCP[s]) >> RCP_SH, exact for x < 2^DIM_W and s < 16
  localparam int RCP_SH     = 13;
  localparam int RCP_W      = 14;
  localparam int PROD_W     = DIM_W + RCP_W;
  localparam int MUL_W      = DIM_W + KS_W;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 9;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam int OUT_DATA_W = SMP_W + 2 * IDX_W;

  localparam logic [CFG_IDX_W-1:0] REG_KERNEL = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STRIDE = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 4'd3;

  localparam logic [KS_W-1:0]  RST_KERNEL = 4'd2;
  localparam logic [KS_W-1:0]  RST_STRIDE = 4'd2;
  localparam logic [DIM_W-1:0] RST_WIDTH  = 9'd32;
  localparam logic [DIM_W-1:0] RST_HEIGHT = 9'd32;

  // cycles the shape check pipeline needs after a register change
  localparam logic [1:0] SETTLE_CYC = 2'd2;

  typedef enum logic [1:0] {
    CMD_WRITE,
    CMD_WINDOW,
    CMD_ERROR
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t                kind;
    logic signed [SMP_W-1:0]  sample;
    logic [SLOT_W-1:0]        slot;
    logic [COL_W-1:0]         col;
    logic [KS_W-1:0]          ksz;
    logic [IDX_W-1:0]         orow;
    logic [IDX_W-1:0]         ocol;
    logic                     last;
  } mp_cmd_t;

  typedef struct packed {
    logic                     empty;
    logic [FIFO_CNT_W-1:0]    count;
  } mp_qstat_t;

  typedef struct packed {
    logic signed [SMP_W-1:0]  pooled;
    logic [IDX_W-1:0]         row;
    logic [IDX_W-1:0]         col;
    logic                     last;
    logic                     err;
  } mp_res_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_FLUSH,
    BK_EMIT
  } bk_state_t;

  function automatic logic [RCP_W-1:0] stride_recip(input logic [KS_W-1:0] s);
    logic [RCP_W-1:0] r;
    unique case (s)
      4'd1:    r = 14'd8192;
      4'd2:    r = 14'd4096;
      4'd3:    r = 14'd2731;
      4'd4:    r = 14'd2048;
      4'd5:    r = 14'd1639;
      4'd6:    r = 14'd1366;
      4'd7:    r = 14'd1171;
      4'd8:    r = 14'd1024;
      4'd9:    r = 14'd911;
      4'd10:   r = 14'd820;
      4'd11:   r = 14'd745;
      4'd12:   r = 14'd683;
      4'd13:   r = 14'd631;
      4'd14:   r = 14'd586;
      4'd15:   r = 14'd547;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/max_pool_2d_stream_core.sv -----
// ----------------------------------------------------------------------------
// max_pool_2d_stream_core
// Streaming 2-D max pooling without padding over raster-order channel planes.
// ----------------------------------------------------------------------------
//  channel | dir | beat contents
//  --------+-----+--------------------------------------------------------------
//  in_     | in  | tdata[15:0] sample (Q8.8)
//  out_    | out | tdata pooled/row/col, tlast last window of plane, tuser error
//  cfg_    | in  | index 0 kernel, 1 stride, 2 width, 3 height; data[8:0]
//
//  The front takes one sample a cycle while the 4-entry command queue has room
//  and cfg_valid is low. Back end: a window-closing sample is stored, then its
//  k*k window is scanned (one line store read port, one entry per cycle).
//  Reset (sync, rst_n low) loads register defaults; in_tready stays low after
//  reset and after each config write while the shape check settles.
//  A stalled out_ channel holds the result register and backs up into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module max_pool_2d_stream_core (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // configuration
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [mp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [mp_pkg::CFG_DATA_W-1:0]      cfg_data,
  // samples
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  input  wire logic [mp_pkg::SMP_W-1:0]           in_tdata,   // [15:0] sample
  // results
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  output logic [mp_pkg::OUT_DATA_W-1:0]           out_tdata,  // [15:0] pooled,
                                                              // [23:16] out_row,
                                                              // [31:24] out_col
  output logic                                    out_tlast,  // last_in_plane
  output logic [0:0]                              out_tuser   // [0] shape_error
);

  import mp_pkg::*;

  logic      q_push;
  mp_cmd_t   q_cmd;
  logic      q_pop;
  mp_cmd_t   q_head;
  mp_qstat_t q_stat;
  mp_res_t   res;

  mp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .q_cmd     (q_cmd)
  );

  mp_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .pop      (q_pop),
    .head     (q_head),
    .stat     (q_stat)
  );

  mp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (q_head),
    .q_stat    (q_stat),
    .pop       (q_pop),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res       (res)
  );

  assign out_tdata    = {res.col, res.row, res.pooled};
  assign out_tlast    = res.last;
  assign out_tuser[0] = res.err;

  // queue credit check must never let a push land on a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> (q_stat.count < FIFO_CNT_W'(FIFO_DEPTH)))
    else $error("command queue overflow");

  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> ((out_tdata == '0) && !out_tlast))
    else $error("error beat carries nonzero fields");

  a_cfg_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_valid && cfg_ready) |=> !in_tready)
    else $error("input accepted before shape check settled");

endmodule

`default_nettype wire

// ----- rtl/mp_ram.sv -----
// ----------------------------------------------------------------------------
// mp_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module mp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/mp_front.sv -----
// ----------------------------------------------------------------------------
// mp_front
// Config registers, shape check, plane position counters and sample
// classification; pushes write / window / error commands into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module mp_front (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [mp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [mp_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [mp_pkg::SMP_W-1:0]        in_tdata,
  input  wire mp_pkg::mp_qstat_t               q_stat,
  output logic                                 q_push,
  output mp_pkg::mp_cmd_t                      q_cmd
);

  import mp_pkg::*;

  // config registers
  logic [KS_W-1:0]  kernel_r, kernel_nxt;
  logic [KS_W-1:0]  stride_r, stride_nxt;
  logic [DIM_W-1:0] width_r, width_nxt;
  logic [DIM_W-1:0] height_r, height_nxt;
  logic [1:0]       settle_r, settle_nxt;
  logic             cfg_wr;

  // shape check pipeline
  logic              gbad1_r, gbad1_nxt;
  logic [DIM_W-1:0]  gwk_r, gwk_nxt;
  logic [DIM_W-1:0]  ghk_r, ghk_nxt;
  logic [PROD_W-1:0] gpw_r, gpw_nxt;
  logic [PROD_W-1:0] gph_r, gph_nxt;
  logic [KS_W-1:0]   gs_r;
  logic              geom_bad_r, geom_bad_nxt;
  logic [MUL_W-1:0]  gmw, gmh;

  // position
  logic [DIM_W-1:0] row_r, row_nxt;
  logic [DIM_W-1:0] col_r, col_nxt;
  logic             plane_bad_r, plane_bad_nxt;

  // accept-time classification
  logic             acc;
  logic             first, bad, kok, cand, wr, err, last;
  logic [DIM_W-1:0] weff, heff;
  logic [DIM_W:0]   r1, c1, k10, r_n, c_n;
  logic [DIM_W-1:0] dr, dc;

  // stage A
  logic              sta_valid_r;
  logic              sta_err_r, sta_wr_r, sta_cand_r, sta_last_r;
  logic [SMP_W-1:0]  sta_sample_r;
  logic [SLOT_W-1:0] sta_slot_r;
  logic [COL_W-1:0]  sta_col_r;
  logic [KS_W-1:0]   sta_k_r, sta_s_r;
  logic [DIM_W-1:0]  sta_dr_r, sta_dc_r;
  logic [PROD_W-1:0] sta_pr_r, sta_pc_r;

  // stage B
  logic [DIM_W-1:0] qr, qc;
  logic [MUL_W-1:0] mr, mc;
  logic             hit;

  // --------------------------------------------------------------------------
  // configuration
  // --------------------------------------------------------------------------
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_comb begin
    kernel_nxt = kernel_r;
    stride_nxt = stride_r;
    width_nxt  = width_r;
    height_nxt = height_r;
    settle_nxt = (settle_r != 2'd0) ? settle_r - 2'd1 : settle_r;
    if (cfg_wr) begin
      settle_nxt = SETTLE_CYC;
      unique case (cfg_index)
        REG_KERNEL: kernel_nxt = cfg_data[KS_W-1:0];
        REG_STRIDE: stride_nxt = cfg_data[KS_W-1:0];
        REG_WIDTH:  width_nxt  = cfg_data[DIM_W-1:0];
        REG_HEIGHT: height_nxt = cfg_data[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kernel_r <= RST_KERNEL;
      stride_r <= RST_STRIDE;
      width_r  <= RST_WIDTH;
      height_r <= RST_HEIGHT;
      settle_r <= SETTLE_CYC;
    end else begin
      kernel_r <= kernel_nxt;
      stride_r <= stride_nxt;
      width_r  <= width_nxt;
      height_r <= height_nxt;
      settle_r <= settle_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // shape check, two stages off the config registers
  // --------------------------------------------------------------------------
  always_comb begin
    gbad1_nxt = (kernel_r == '0) || (stride_r == '0) ||
                (kernel_r > KS_W'(MAX_KERNEL)) ||
                (width_r == '0) || (height_r == '0) ||
                (width_r > DIM_W'(MAX_WIDTH)) ||
                (DIM_W'(kernel_r) > width_r) || (DIM_W'(kernel_r) > height_r);
    gwk_nxt   = width_r - DIM_W'(kernel_r);
    ghk_nxt   = height_r - DIM_W'(kernel_r);
    gpw_nxt   = PROD_W'(gwk_nxt) * PROD_W'(stride_recip(stride_r));
    gph_nxt   = PROD_W'(ghk_nxt) * PROD_W'(stride_recip(stride_r));
    gmw       = MUL_W'(gpw_r[RCP_SH +: DIM_W]) * MUL_W'(gs_r);
    gmh       = MUL_W'(gph_r[RCP_SH +: DIM_W]) * MUL_W'(gs_r);
    geom_bad_nxt = gbad1_r || (gmw != MUL_W'(gwk_r)) || (gmh != MUL_W'(ghk_r));
  end

  always_ff @(posedge clk) begin
    gbad1_r    <= gbad1_nxt;
    gwk_r      <= gwk_nxt;
    ghk_r      <= ghk_nxt;
    gpw_r      <= gpw_nxt;
    gph_r      <= gph_nxt;
    gs_r       <= stride_r;
    geom_bad_r <= geom_bad_nxt;
  end

  // --------------------------------------------------------------------------
  // accept and classify
  // --------------------------------------------------------------------------
  assign in_tready = (settle_r == 2'd0) && !cfg_valid &&
                     ((FIFO_CNT_W+1)'(q_stat.count) + (FIFO_CNT_W+1)'(sta_valid_r)
                      < (FIFO_CNT_W+1)'(FIFO_DEPTH));
  assign acc = in_tvalid && in_tready;

  always_comb begin
    first = (row_r == '0) && (col_r == '0);
    bad   = first ? geom_bad_r : plane_bad_r;
    weff  = (width_r == '0) ? DIM_W'(1) : width_r;
    heff  = (height_r == '0) ? DIM_W'(1) : height_r;
    r1    = (DIM_W+1)'(row_r) + (DIM_W+1)'(1);
    c1    = (DIM_W+1)'(col_r) + (DIM_W+1)'(1);
    k10   = (DIM_W+1)'(kernel_r);
    kok   = (kernel_r != '0) && (stride_r != '0) && (kernel_r <= KS_W'(MAX_KERNEL));
    wr    = !bad && !col_r[DIM_W-1];
    cand  = wr && kok && (r1 >= k10) && (c1 >= k10);
    err   = first && geom_bad_r;
    last  = (r1 >= (DIM_W+1)'(heff)) && (c1 >= (DIM_W+1)'(weff));
    dr    = DIM_W'(r1 - k10);
    dc    = DIM_W'(c1 - k10);

    // next position, with wrap when the dimensions shrank mid-plane
    c_n = c1;
    r_n = (DIM_W+1)'(row_r);
    if (c1 >= (DIM_W+1)'(weff)) begin
      c_n = '0;
      r_n = r1;
      if (r1 >= (DIM_W+1)'(heff)) begin
        r_n = '0;
      end
    end
    if (r_n >= (DIM_W+1)'(heff)) begin
      r_n = '0;
      c_n = '0;
    end

    row_nxt       = row_r;
    col_nxt       = col_r;
    plane_bad_nxt = plane_bad_r;
    if (acc) begin
      row_nxt       = r_n[DIM_W-1:0];
      col_nxt       = c_n[DIM_W-1:0];
      plane_bad_nxt = bad;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r       <= '0;
      col_r       <= '0;
      plane_bad_r <= 1'b0;
      sta_valid_r <= 1'b0;
    end else begin
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      plane_bad_r <= plane_bad_nxt;
      sta_valid_r <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      sta_err_r    <= err;
      sta_wr_r     <= wr;
      sta_cand_r   <= cand;
      sta_last_r   <= last;
      sta_sample_r <= in_tdata;
      sta_slot_r   <= row_r[SLOT_W-1:0];
      sta_col_r    <= col_r[COL_W-1:0];
      sta_k_r      <= kernel_r;
      sta_s_r      <= stride_r;
      sta_dr_r     <= dr;
      sta_dc_r     <= dc;
      sta_pr_r     <= PROD_W'(dr) * PROD_W'(stride_recip(stride_r));
      sta_pc_r     <= PROD_W'(dc) * PROD_W'(stride_recip(stride_r));
    end
  end

  // --------------------------------------------------------------------------
  // stage B: window origin on the stride grid, then push
  // --------------------------------------------------------------------------
  always_comb begin
    qr  = sta_pr_r[RCP_SH +: DIM_W];
    qc  = sta_pc_r[RCP_SH +: DIM_W];
    mr  = MUL_W'(qr) * MUL_W'(sta_s_r);
    mc  = MUL_W'(qc) * MUL_W'(sta_s_r);
    hit = sta_cand_r && (mr == MUL_W'(sta_dr_r)) && (mc == MUL_W'(sta_dc_r));

    q_push       = sta_valid_r && (sta_err_r || sta_wr_r);
    q_cmd.sample = sta_sample_r;
    q_cmd.slot   = sta_slot_r;
    q_cmd.col    = sta_col_r;
    q_cmd.ksz    = sta_k_r;
    q_cmd.orow   = qr[IDX_W-1:0];
    q_cmd.ocol   = qc[IDX_W-1:0];
    q_cmd.last   = sta_last_r;
    priority if (sta_err_r) begin
      q_cmd.kind = CMD_ERROR;
    end else if (hit) begin
      q_cmd.kind = CMD_WINDOW;
    end else begin
      q_cmd.kind = CMD_WRITE;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/mp_fifo.sv -----
// ----------------------------------------------------------------------------
// mp_fifo
// Short command queue between the classifier and the window engine.
// ----------------------------------------------------------------------------
`default_nettype none

module mp_fifo (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire mp_pkg::mp_cmd_t  push_cmd,
  input  wire logic             pop,
  output mp_pkg::mp_cmd_t       head,
  output mp_pkg::mp_qstat_t     stat
);

  import mp_pkg::*;

  mp_cmd_t               mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CNT_W-1:0] count_r, count_nxt;
  logic                  do_pop;

  assign do_pop     = pop && (count_r != '0);
  assign head       = mem_r[rd_ptr_r];
  assign stat.empty = (count_r == '0);
  assign stat.count = count_r;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + FIFO_PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + FIFO_PTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r + FIFO_CNT_W'(push) - FIFO_CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/mp_back.sv -----
// ----------------------------------------------------------------------------
// mp_back
// Window engine: writes samples to the line store, scans k x k windows one
// entry a cycle, and holds the result register toward the output.
// ----------------------------------------------------------------------------
`default_nettype none

module mp_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire mp_pkg::mp_cmd_t  head,
  input  wire mp_pkg::mp_qstat_t q_stat,
  output logic                  pop,
  output logic                  res_valid,
  input  wire logic             res_ready,
  output mp_pkg::mp_res_t       res
);

  import mp_pkg::*;

  bk_state_t               state_r, state_nxt;
  logic [SLOT_W-1:0]       m_r, m_nxt;
  logic [SLOT_W-1:0]       n_r, n_nxt;
  logic [SLOT_W-1:0]       slot_r, slot_nxt;
  logic [COL_W-1:0]        col_r, col_nxt;
  logic [SLOT_W-1:0]       kl_r, kl_nxt;
  logic [IDX_W-1:0]        orow_r, orow_nxt;
  logic [IDX_W-1:0]        ocol_r, ocol_nxt;
  logic                    last_r, last_nxt;
  logic signed [SMP_W-1:0] best_r, best_nxt;
  logic                    rdv_r;

  logic                    out_valid_r, out_valid_nxt;
  mp_res_t                 out_res_r, out_res_nxt;
  logic                    out_free;
  logic                    load_out;
  mp_res_t                 load_res;

  logic                    we, re;
  logic [ADDR_W-1:0]       waddr, raddr;
  logic [SMP_W-1:0]        rdata;
  logic [KS_W-1:0]         head_kl;

  mp_ram #(
    .WIDTH (SMP_W),
    .DEPTH (RAM_DEPTH)
  ) u_line_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (head.sample),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign out_free  = !out_valid_r || res_ready;
  assign waddr     = {head.slot, head.col};
  assign raddr     = {slot_r - m_r, col_r - COL_W'(n_r)};
  assign head_kl   = head.ksz - KS_W'(1);
  assign res_valid = out_valid_r;
  assign res       = out_res_r;

  always_comb begin
    state_nxt = state_r;
    m_nxt     = m_r;
    n_nxt     = n_r;
    slot_nxt  = slot_r;
    col_nxt   = col_r;
    kl_nxt    = kl_r;
    orow_nxt  = orow_r;
    ocol_nxt  = ocol_r;
    last_nxt  = last_r;
    best_nxt  = best_r;
    pop       = 1'b0;
    we        = 1'b0;
    re        = 1'b0;
    load_out  = 1'b0;
    load_res  = '0;

    // read data lands in the cycle after its address
    if (rdv_r && ($signed(rdata) > best_r)) begin
      best_nxt = $signed(rdata);
    end

    unique case (state_r)
      BK_IDLE: begin
        if (!q_stat.empty) begin
          unique case (head.kind)
            CMD_WRITE: begin
              we  = 1'b1;
              pop = 1'b1;
            end
            CMD_WINDOW: begin
              we        = 1'b1;
              pop       = 1'b1;
              slot_nxt  = head.slot;
              col_nxt   = head.col;
              kl_nxt    = head_kl[SLOT_W-1:0];
              orow_nxt  = head.orow;
              ocol_nxt  = head.ocol;
              last_nxt  = head.last;
              best_nxt  = head.sample;
              m_nxt     = '0;
              n_nxt     = '0;
              state_nxt = BK_SCAN;
            end
            CMD_ERROR: begin
              if (out_free) begin
                load_out     = 1'b1;
                load_res.err = 1'b1;
                pop          = 1'b1;
              end
            end
            default: pop = 1'b1;
          endcase
        end
      end
      BK_SCAN: begin
        re = 1'b1;
        if (n_r == kl_r) begin
          n_nxt = '0;
          if (m_r == kl_r) begin
            state_nxt = BK_FLUSH;
          end else begin
            m_nxt = m_r + SLOT_W'(1);
          end
        end else begin
          n_nxt = n_r + SLOT_W'(1);
        end
      end
      BK_FLUSH: begin
        state_nxt = BK_EMIT;
      end
      BK_EMIT: begin
        if (out_free) begin
          load_out        = 1'b1;
          load_res.pooled = best_r;
          load_res.row    = orow_r;
          load_res.col    = ocol_r;
          load_res.last   = last_r;
          load_res.err    = 1'b0;
          state_nxt       = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase

    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = load_res;
    end else if (res_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      rdv_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rdv_r       <= re;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    m_r       <= m_nxt;
    n_r       <= n_nxt;
    slot_r    <= slot_nxt;
    col_r     <= col_nxt;
    kl_r      <= kl_nxt;
    orow_r    <= orow_nxt;
    ocol_r    <= ocol_nxt;
    last_r    <= last_nxt;
    best_r    <= best_nxt;
    out_res_r <= out_res_nxt;
  end

endmodule

`default_nettype wire
